### design/hcd_pkg.sv
// ---------------------------------------------------------------------------
// hcd_pkg: shared types and constants for the chunk deframer
// Character codes, result kinds, phase encoding and the hex digit decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

    localparam int DEF_LENGTH_BITS = 24;
    localparam int MAX_W           = 24;
    localparam logic [MAX_W-1:0] MAX_RESET = 24'hFF_FFFF;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF_HEX = 8'h46;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    typedef enum logic [2:0] {
        K_FRAME = 3'd0,
        K_DATA  = 3'd1,
        K_LAST  = 3'd2,
        K_EMPTY = 3'd3,
        K_ERROR = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_SIZE = 4'b0001,
        PH_DATA = 4'b0010,
        PH_TAIL = 4'b0100,
        PH_ERR  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] payload;
        kind_t      kind;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t       h;
        logic [7:0] diff;
        h    = '{ok: 1'b0, value: 4'd0};
        diff = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff = c - CH_ZERO;
            h    = '{ok: 1'b1, value: diff[3:0]};
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            diff = c - CH_LA + HEX_TEN;
            h    = '{ok: 1'b1, value: diff[3:0]};
        end else if (c >= CH_UA && c <= CH_UF_HEX) begin
            diff = c - CH_UA + HEX_TEN;
            h    = '{ok: 1'b1, value: diff[3:0]};
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### design/hcd_in_reg.sv
// ---------------------------------------------------------------------------
// hcd_in_reg: input register
// Holds one received byte until the decode stage takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module hcd_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            held_valid,
    output logic [7:0]      held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // free, or emptying this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

### design/hcd_step.sv
// ---------------------------------------------------------------------------
// hcd_step: framing state machine
// Phase and chunk length registers plus the per-byte decode.
// ---------------------------------------------------------------------------
`default_nettype none

module hcd_step #(
    parameter int LENGTH_BITS = hcd_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire logic [7:0]                cur_byte,
    input  wire logic [hcd_pkg::MAX_W-1:0] max_len,
    output hcd_pkg::result_t               res
);
    import hcd_pkg::*;

    localparam int NW = LENGTH_BITS + 4;
    localparam int CW = (NW > MAX_W) ? NW : MAX_W;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    logic [NW-1:0]          len_acc;
    hex_t                   hex;

    assign hex     = hex_decode(cur_byte);
    assign len_acc = {count_reg, 4'b0000} + NW'(hex.value);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        res.payload = 8'd0;
        res.kind    = K_FRAME;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (cur_byte == CH_CR)
                begin
                    res.kind = K_FRAME;
                end
                else if (cur_byte == CH_LF)
                begin
                    if (count_reg == '0)
                    begin
                        res.kind   = K_EMPTY;
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else if (!hex.ok)
                begin
                    res.kind   = K_ERROR;
                    phase_next = PH_ERR;
                end
                else if ((CW'(len_acc) > CW'(max_len)) || (len_acc[NW-1 -: 4] != 4'd0))
                begin
                    // over the configured limit or out of counter range
                    res.kind   = K_ERROR;
                    phase_next = PH_ERR;
                end
                else
                begin
                    count_next = len_acc[LENGTH_BITS-1:0];
                end
            end
            PH_DATA:
            begin
                res.payload = cur_byte;
                if (count_reg <= LENGTH_BITS'(1))
                begin
                    count_next = '0;
                    res.kind   = K_LAST;
                    phase_next = PH_TAIL;
                end
                else
                begin
                    count_next = count_reg - LENGTH_BITS'(1);
                    res.kind   = K_DATA;
                end
            end
            PH_TAIL:
            begin
                if (cur_byte == CH_LF)
                begin
                    phase_next = PH_SIZE;
                    count_next = '0;
                end
                else if (cur_byte != CH_CR)
                begin
                    res.kind   = K_ERROR;
                    phase_next = PH_ERR;
                end
            end
            PH_ERR:
            begin
                res.kind = K_ERROR;
            end
            default:
            begin
                res.kind   = K_ERROR;
                phase_next = PH_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // error is sticky
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR |=> phase_reg == PH_ERR)
        else $error("left error phase");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_ERR |-> res.kind == K_ERROR)
        else $error("non-error result in error phase");

    a_last_to_tail: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_DATA && res.kind == K_LAST |=> phase_reg == PH_TAIL)
        else $error("last payload did not end chunk");

    a_tail_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TAIL |-> count_reg == '0)
        else $error("count not cleared after payload");

endmodule

`default_nettype wire

### design/hcd_out_reg.sv
// ---------------------------------------------------------------------------
// hcd_out_reg: result register
// Holds one result transfer until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module hcd_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire hcd_pkg::result_t res,
    output logic                  can_take,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            payload_byte,
    output logic [2:0]            kind
);
    import hcd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_take = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign payload_byte = res_reg.payload;
    assign kind         = 3'(res_reg.kind);

endmodule

`default_nettype wire

### design/http_chunk_deframer_unit.sv
// ---------------------------------------------------------------------------
// http_chunk_deframer_unit: HTTP chunked transfer deframer
// One received byte per input transfer, one result transfer per byte.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries rx_byte, the chunked stream in
//   order. Output channel out_valid/out_ready carries payload_byte and kind
//   (framing, payload, last payload of chunk, empty chunk, error).
//   cfg_wr_en/cfg_wr_data set max_chunk_size; write only while idle.
// Path: an accepted byte is held in the input register, and its result is
//   registered in the result register, which drives out_valid.
// Throughput: one byte per clock while out_ready is high. The phase/length
//   update is a single decode between the input register and the result
//   register, so bytes stream back to back.
// Stall: while out_ready is low a full result register holds; an empty
//   input register still takes one more byte, then in_ready drops.
// Reset: both registers empty, phase back to size line, length zero,
//   max_chunk_size back to all ones. An error phase lasts until reset.
// ---------------------------------------------------------------------------
`default_nettype none

module http_chunk_deframer_unit #(
    parameter int LENGTH_BITS = hcd_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                rx_byte,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     payload_byte,
    output logic [2:0]                     kind,
    input  wire logic                      cfg_wr_en,
    input  wire logic [hcd_pkg::MAX_W-1:0] cfg_wr_data
);
    import hcd_pkg::*;

    logic             held_valid;
    logic [7:0]       held_byte;
    logic             can_take;
    logic             advance;
    result_t          res;
    logic [MAX_W-1:0] max_len_reg;

    // byte moves from input register into result register
    assign advance = held_valid && can_take;

    // chunk length limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    hcd_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    hcd_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (held_byte),
        .max_len  (max_len_reg),
        .res      (res)
    );

    hcd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .res          (res),
        .can_take     (can_take),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_byte (payload_byte),
        .kind         (kind)
    );

endmodule

`default_nettype wire
